// ===== sv/json_string_escaper_utf8_assert.svh =====
// Assertion macros used by the checker file of the JSON string escaper.
`ifndef JSON_STRING_ESCAPER_UTF8_ASSERT_SVH
`define JSON_STRING_ESCAPER_UTF8_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define JSE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define JSE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/jse_pkg.sv =====
`timescale 1ns / 1ps

package jse_pkg;

    // Token queue between decoder and expander; depth must be a power of two
    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
    localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Capacity register value after reset
    localparam logic [15:0] CAP_RESET = 16'hffff;

    // Characters
    localparam logic [7:0] CH_BSL   = 8'h5c;
    localparam logic [7:0] CH_QUOT  = 8'h22;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6e;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CTL_BS   = 8'h08;
    localparam logic [7:0] CTL_FF   = 8'h0c;
    localparam logic [7:0] CTL_LF   = 8'h0a;
    localparam logic [7:0] CTL_CR   = 8'h0d;
    localparam logic [7:0] CTL_TAB  = 8'h09;
    localparam logic [7:0] CTL_LAST = 8'h1f;

    // UTF-8 limits
    localparam logic [15:0] CP_REPL   = 16'hfffd;
    localparam logic [20:0] CP_MAX    = 21'h10ffff;
    localparam logic [20:0] CP_BMPMAX = 21'h00ffff;
    localparam logic [20:0] CP_SUPP   = 21'h010000;
    localparam logic [15:0] SUR_HI    = 16'hd800;
    localparam logic [15:0] SUR_LO    = 16'hdc00;

    // Output token kinds
    typedef enum logic [2:0] {
        TK_LIT  = 3'd0,   // one literal character
        TK_ESC  = 3'd1,   // backslash plus one character
        TK_U4   = 3'd2,   // \uxxxx
        TK_PAIR = 3'd3,   // \uxxxx\uxxxx surrogate pair
        TK_END  = 3'd4    // string terminator
    } tok_kind_t;

    // data[15:0]: char or code unit; data[31:16]: high surrogate of a pair
    typedef struct packed {
        tok_kind_t   kind;
        logic [31:0] data;
    } tok_t;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] ext;
        ext = {4'h0, nib};
        return (nib < 4'd10) ? (8'h30 + ext) : (8'h57 + ext);
    endfunction

    function automatic logic is_cont(input logic [7:0] b);
        return b[7:6] == 2'b10;
    endfunction

endpackage

// ===== sv/jse_front.sv =====
`timescale 1ns / 1ps

module jse_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic [7:0]    s_in_byte,
    output logic          tok_valid,
    input  logic          tok_ready,
    output jse_pkg::tok_t tok
);

    // Lookahead buffer: up to one full UTF-8 sequence
    logic [7:0] buf_reg  [4];
    logic [7:0] buf_next [4];
    logic [2:0] cnt_reg, cnt_next;
    logic       end_reg, end_next;

    logic [7:0]  c1, c2, c3, c4;
    logic [1:0]  need;
    logic        step_valid;
    logic [2:0]  used;
    logic [20:0] cp3;
    logic [20:0] w;
    logic        fire;
    logic [2:0]  used_eff;
    logic [2:0]  n_after;
    logic [31:0] word, shifted;
    logic        accept;

    assign c1  = buf_reg[0];
    assign c2  = buf_reg[1];
    assign c3  = buf_reg[2];
    assign c4  = buf_reg[3];
    assign cp3 = {c1[2:0], c2[5:0], c3[5:0], c4[5:0]};
    assign w   = cp3 - jse_pkg::CP_SUPP;

    // Sequence length from the lead byte
    always_comb begin
        if (c1[7:5] == 3'b110) begin
            need = 2'd1;
        end else if (c1[7:4] == 4'b1110) begin
            need = 2'd2;
        end else if (c1[7:3] == 5'b11110) begin
            need = 2'd3;
        end else begin
            need = 2'd0;
        end
    end

    // Judge the head of the buffer: one token per cycle while the queue takes it and the head is complete
    always_comb begin
        step_valid = 1'b0;
        used       = 3'd0;
        tok.kind   = jse_pkg::TK_LIT;
        tok.data   = '0;
        if (cnt_reg == 3'd0) begin
            if (end_reg) begin
                step_valid = 1'b1;
                tok.kind   = jse_pkg::TK_END;
            end
        end else if (!c1[7]) begin
            step_valid = 1'b1;
            used       = 3'd1;
            tok.kind   = jse_pkg::TK_ESC;
            case (c1)
                jse_pkg::CH_BSL:  tok.data = {24'h0, jse_pkg::CH_BSL};
                jse_pkg::CH_QUOT: tok.data = {24'h0, jse_pkg::CH_QUOT};
                jse_pkg::CTL_BS:  tok.data = {24'h0, jse_pkg::CH_B};
                jse_pkg::CTL_FF:  tok.data = {24'h0, jse_pkg::CH_F};
                jse_pkg::CTL_LF:  tok.data = {24'h0, jse_pkg::CH_N};
                jse_pkg::CTL_CR:  tok.data = {24'h0, jse_pkg::CH_R};
                jse_pkg::CTL_TAB: tok.data = {24'h0, jse_pkg::CH_T};
                default: begin
                    tok.kind = (c1 > jse_pkg::CTL_LAST) ? jse_pkg::TK_LIT : jse_pkg::TK_U4;
                    tok.data = {24'h0, c1};
                end
            endcase
        end else if (need != 2'd0 && cnt_reg <= {1'b0, need} && !end_reg) begin
            // incomplete sequence: wait for more bytes
            step_valid = 1'b0;
        end else begin
            step_valid = 1'b1;
            used       = 3'd1;
            tok.kind   = jse_pkg::TK_U4;
            tok.data   = {16'h0, jse_pkg::CP_REPL};
            if (need == 2'd1 && cnt_reg >= 3'd2 && c1 >= 8'hc2 && jse_pkg::is_cont(c2)) begin
                used     = 3'd2;
                tok.data = {21'h0, c1[4:0], c2[5:0]};
            end else if (need == 2'd2 && cnt_reg >= 3'd3
                         && (c1 != 8'he0 || c2 >= 8'ha0)
                         && (c1 != 8'hed || c2 <= 8'h9f)
                         && jse_pkg::is_cont(c2) && jse_pkg::is_cont(c3)) begin
                used     = 3'd3;
                tok.data = {16'h0, c1[3:0], c2[5:0], c3[5:0]};
            end else if (need == 2'd3 && cnt_reg == 3'd4
                         && (c1 != 8'hf0 || c2 >= 8'h90) && c1 <= 8'hf4
                         && jse_pkg::is_cont(c2) && jse_pkg::is_cont(c3)
                         && jse_pkg::is_cont(c4) && cp3 <= jse_pkg::CP_MAX) begin
                used = 3'd4;
                if (cp3 <= jse_pkg::CP_BMPMAX) begin
                    tok.data = {16'h0, cp3[15:0]};
                end else begin
                    tok.kind = jse_pkg::TK_PAIR;
                    tok.data = {jse_pkg::SUR_HI | {6'h0, w[19:10]},
                                jse_pkg::SUR_LO | {6'h0, w[9:0]}};
                end
            end
        end
    end

    assign tok_valid = step_valid;
    assign fire      = step_valid && tok_ready;
    assign used_eff  = fire ? used : 3'd0;
    assign n_after   = cnt_reg - used_eff;

    // Take a byte whenever a slot is free after this cycle's step and no terminator is pending
    assign s_ready = aresetn && !end_reg && (n_after != 3'd4);
    assign accept  = s_valid && s_ready;

    assign word    = {buf_reg[3], buf_reg[2], buf_reg[1], buf_reg[0]};
    assign shifted = word >> {used_eff, 3'b000};

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            buf_next[k] = shifted[8*k +: 8];
            if (accept && s_in_byte != 8'h00 && n_after == 3'(k)) begin
                buf_next[k] = s_in_byte;
            end
        end
        cnt_next = n_after;
        end_next = end_reg;
        if (fire && tok.kind == jse_pkg::TK_END) begin
            end_next = 1'b0;
        end
        if (accept) begin
            if (s_in_byte == 8'h00) begin
                end_next = 1'b1;
            end else begin
                cnt_next = n_after + 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 3'd0;
            end_reg <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            end_reg <= end_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < 4; k++) begin
            buf_reg[k] <= buf_next[k];
        end
    end

endmodule

// ===== sv/jse_queue.sv =====
`timescale 1ns / 1ps

module jse_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  jse_pkg::tok_t in_tok,
    output logic          out_valid,
    input  logic          out_ready,
    output jse_pkg::tok_t out_tok
);

    jse_pkg::tok_t                 mem_reg [jse_pkg::Q_DEPTH];
    logic [jse_pkg::Q_PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [jse_pkg::Q_CNT_W-1:0]   cnt_reg, cnt_next;
    logic                          push, pop;

    assign in_ready  = cnt_reg != jse_pkg::Q_CNT_W'(jse_pkg::Q_DEPTH);
    assign out_valid = cnt_reg != '0;
    assign out_tok   = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    // Pointers wrap naturally (power-of-two depth)
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_tok;
        end
    end

endmodule

// ===== sv/jse_back.sv =====
`timescale 1ns / 1ps

module jse_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic [15:0]   out_capacity,
    input  logic          tok_valid,
    output logic          tok_ready,
    input  jse_pkg::tok_t tok,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [7:0]    m_out_char,
    output logic          m_done_res,
    output logic          m_overflow,
    output logic [15:0]   m_total_length
);

    logic [3:0]  idx_reg, idx_next;
    logic [15:0] written_reg, written_next;
    logic        aborted_reg, aborted_next;

    logic        m_valid_reg, m_valid_next;
    logic [7:0]  m_out_char_reg, m_out_char_next;
    logic        m_done_res_reg, m_done_res_next;
    logic        m_overflow_reg, m_overflow_next;
    logic [15:0] m_total_length_reg, m_total_length_next;

    logic        can_out, room, load, is_last, second_half;
    logic [3:0]  last_idx, sub;
    logic [15:0] val;
    logic [3:0]  nib;
    logic [7:0]  ch;

    assign can_out = !m_valid_reg || m_ready;
    assign room    = written_reg < out_capacity;

    // Index of the last character of each token
    always_comb begin
        case (tok.kind)
            jse_pkg::TK_LIT:  last_idx = 4'd0;
            jse_pkg::TK_ESC:  last_idx = 4'd1;
            jse_pkg::TK_U4:   last_idx = 4'd5;
            jse_pkg::TK_PAIR: last_idx = 4'd11;
            default:          last_idx = 4'd0;
        endcase
    end
    assign is_last = idx_reg == last_idx;

    // Pick the current character of the token
    assign second_half = (tok.kind == jse_pkg::TK_PAIR) && (idx_reg >= 4'd6);
    assign sub = second_half ? (idx_reg - 4'd6) : idx_reg;
    assign val = (tok.kind == jse_pkg::TK_PAIR && !second_half) ? tok.data[31:16]
                                                                 : tok.data[15:0];
    always_comb begin
        case (sub[2:0])
            3'd2:    nib = val[15:12];
            3'd3:    nib = val[11:8];
            3'd4:    nib = val[7:4];
            default: nib = val[3:0];
        endcase
    end

    always_comb begin
        case (tok.kind)
            jse_pkg::TK_LIT: ch = tok.data[7:0];
            jse_pkg::TK_ESC: ch = (idx_reg == 4'd0) ? jse_pkg::CH_BSL : tok.data[7:0];
            jse_pkg::TK_U4, jse_pkg::TK_PAIR: begin
                if (sub == 4'd0) begin
                    ch = jse_pkg::CH_BSL;
                end else if (sub == 4'd1) begin
                    ch = jse_pkg::CH_U;
                end else begin
                    ch = jse_pkg::hex_char(nib);
                end
            end
            default: ch = jse_pkg::CH_NUL;
        endcase
    end

    // Expansion, capacity check and abort handling
    always_comb begin
        idx_next            = idx_reg;
        written_next        = written_reg;
        aborted_next        = aborted_reg;
        tok_ready           = 1'b0;
        load                = 1'b0;
        m_out_char_next     = m_out_char_reg;
        m_done_res_next     = m_done_res_reg;
        m_overflow_next     = m_overflow_reg;
        m_total_length_next = m_total_length_reg;
        if (tok_valid) begin
            if (aborted_reg) begin
                // drop everything up to the terminator
                tok_ready = 1'b1;
                idx_next  = 4'd0;
                if (tok.kind == jse_pkg::TK_END) begin
                    aborted_next = 1'b0;
                end
            end else if (can_out) begin
                load = 1'b1;
                if (tok.kind == jse_pkg::TK_END) begin
                    tok_ready       = 1'b1;
                    idx_next        = 4'd0;
                    written_next    = 16'd0;
                    m_out_char_next = jse_pkg::CH_NUL;
                    m_done_res_next = 1'b1;
                    m_overflow_next = !room;
                    m_total_length_next = room ? (written_reg + 16'd1) : 16'd0;
                end else if (room) begin
                    written_next        = written_reg + 16'd1;
                    m_out_char_next     = ch;
                    m_done_res_next     = 1'b0;
                    m_overflow_next     = 1'b0;
                    m_total_length_next = 16'd0;
                    if (is_last) begin
                        tok_ready = 1'b1;
                        idx_next  = 4'd0;
                    end else begin
                        idx_next = idx_reg + 4'd1;
                    end
                end else begin
                    tok_ready           = 1'b1;
                    idx_next            = 4'd0;
                    written_next        = 16'd0;
                    aborted_next        = 1'b1;
                    m_out_char_next     = jse_pkg::CH_NUL;
                    m_done_res_next     = 1'b1;
                    m_overflow_next     = 1'b1;
                    m_total_length_next = 16'd0;
                end
            end
        end
        m_valid_next = load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= 4'd0;
            written_reg <= 16'd0;
            aborted_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            idx_reg     <= idx_next;
            written_reg <= written_next;
            aborted_reg <= aborted_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_out_char_reg     <= m_out_char_next;
        m_done_res_reg     <= m_done_res_next;
        m_overflow_reg     <= m_overflow_next;
        m_total_length_reg <= m_total_length_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_out_char     = m_out_char_reg;
    assign m_done_res     = m_done_res_reg;
    assign m_overflow     = m_overflow_reg;
    assign m_total_length = m_total_length_reg;

endmodule

// ===== sv/json_string_escaper_utf8.sv =====
`timescale 1ns / 1ps

// JSON string escaper with UTF-8 validation. Bytes of a string enter on the
// s_ channel (0 ends the string); the escaped text leaves one character per
// transaction on the m_ channel, closed by a NUL that carries done and the
// total length, or by a single overflow result once out_capacity would be
// exceeded (the rest of that string is then dropped up to its terminator).
// The decoder judges one character or one UTF-8 sequence per cycle while
// the 4-entry token queue it feeds has room; the expander writes one output
// character per cycle while m_ready does not stall it. Plain ASCII therefore
// streams at one byte per cycle without stalls; a byte or sequence that
// becomes an escape expands to 2, 6 or 12 characters, and input stalls once
// the queue is full. A terminator token follows the bytes still held.
module json_string_escaper_utf8 (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_char,
    output logic        m_done_res,
    output logic        m_overflow,
    output logic [15:0] m_total_length
);

    logic [15:0]   out_capacity_reg;
    logic          f_tok_valid, f_tok_ready;
    jse_pkg::tok_t f_tok;
    logic          b_tok_valid, b_tok_ready;
    jse_pkg::tok_t b_tok;

    // Capacity register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_capacity_reg <= jse_pkg::CAP_RESET;
        end else if (cfg_wr_en) begin
            out_capacity_reg <= cfg_wr_data;
        end
    end

    jse_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_in_byte (s_in_byte),
        .tok_valid (f_tok_valid),
        .tok_ready (f_tok_ready),
        .tok       (f_tok)
    );

    jse_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_tok_valid),
        .in_ready  (f_tok_ready),
        .in_tok    (f_tok),
        .out_valid (b_tok_valid),
        .out_ready (b_tok_ready),
        .out_tok   (b_tok)
    );

    jse_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .out_capacity   (out_capacity_reg),
        .tok_valid      (b_tok_valid),
        .tok_ready      (b_tok_ready),
        .tok            (b_tok),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_char     (m_out_char),
        .m_done_res     (m_done_res),
        .m_overflow     (m_overflow),
        .m_total_length (m_total_length)
    );

endmodule

// ===== sv/jse_checker.sv =====
`timescale 1ns / 1ps
`include "json_string_escaper_utf8_assert.svh"

module jse_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [7:0]  m_out_char,
    input logic        m_done_res,
    input logic        m_overflow,
    input logic [15:0] m_total_length
);

    // Overflow result closes the string and carries no character or length
    `JSE_ASSERT_NOW(a_ovf_result, aclk, aresetn, m_valid && m_overflow, m_done_res && m_out_char == 8'h00 && m_total_length == 16'd0, "overflow result malformed")

    // The final NUL carries a nonzero length
    `JSE_ASSERT_NOW(a_nul_result, aclk, aresetn, m_valid && m_done_res && !m_overflow, m_out_char == 8'h00 && m_total_length != 16'd0, "terminating NUL malformed")

    // Text characters are never NUL and carry no length or flags
    `JSE_ASSERT_NOW(a_text_result, aclk, aresetn, m_valid && !m_done_res, m_out_char != 8'h00 && !m_overflow && m_total_length == 16'd0, "text character malformed")

    // A stalled result transaction holds
    `JSE_ASSERT_NXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_out_char) && $stable(m_done_res) && $stable(m_total_length), "result changed while stalled")

endmodule

bind json_string_escaper_utf8 jse_checker u_jse_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_out_char     (m_out_char),
    .m_done_res     (m_done_res),
    .m_overflow     (m_overflow),
    .m_total_length (m_total_length)
);

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    // Cycles without any transaction before the run is declared hung
    localparam int STALL_LIMIT = 1000;
    // Quiet cycles after the last expected char, covering the decoder pipeline
    localparam int DRAIN_CYCLES = 24;
    localparam logic [127:0] HEX_ASCII = "0123456789abcdef";

    typedef struct packed {
        logic [7:0]  ch;
        logic        done;
        logic        ovf;
        logic [15:0] len;
    } esc_char_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [15:0] cfg_wr_data = 16'h0000;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_in_byte = 8'h00;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_out_char;
    logic        m_done_res;
    logic        m_overflow;
    logic [15:0] m_total_length;

    json_string_escaper_utf8 dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_in_byte     (s_in_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_char    (m_out_char),
        .m_done_res    (m_done_res),
        .m_overflow    (m_overflow),
        .m_total_length(m_total_length)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Escaper model state
    logic [7:0]  utf_buf [0:3];
    int unsigned utf_n;
    logic [7:0]  held_q [0:2];
    int unsigned held_n = 0;
    logic [15:0] chars_written = 16'h0000;
    bit          str_aborted = 1'b0;
    bit          str_halted = 1'b0;
    logic [15:0] out_cap = jse_pkg::CAP_RESET;
    esc_char_t   expected_chars [$];

    // Stimulus bookkeeping
    logic [7:0]  pending_bytes [$];
    logic [7:0]  directed_bytes [25];
    int          bytes_total = 0;
    int          bytes_sent = 0;
    int          bytes_taken = 0;
    int          mismatches = 0;
    int          stall_cycles = 0;
    int          in_gap = 0;
    int          out_gap = 0;
    bit          idle_on = 1'b1;
    esc_char_t   want;

    function automatic void push_char(logic [7:0] ch, logic done, logic ovf, logic [15:0] len);
        esc_char_t r;
        r.ch = ch;
        r.done = done;
        r.ovf = ovf;
        r.len = len;
        expected_chars.push_back(r);
    endfunction

    function automatic void raise_overflow();
        push_char(jse_pkg::CH_NUL, 1'b1, 1'b1, 16'h0000);
        str_aborted = 1'b1;
        held_n = 0;
        chars_written = 16'h0000;
        str_halted = 1'b1;
    endfunction

    function automatic void write_char(logic [7:0] ch);
        if (!str_halted) begin
            if (chars_written < out_cap) begin
                chars_written = chars_written + 16'd1;
                push_char(ch, 1'b0, 1'b0, 16'h0000);
            end else begin
                raise_overflow();
            end
        end
    endfunction

    function automatic void write_u4(logic [15:0] cu);
        logic [3:0] nib;
        write_char(jse_pkg::CH_BSL);
        write_char(jse_pkg::CH_U);
        for (int k = 3; k >= 0; k--) begin
            nib = cu[4*k +: 4];
            write_char(HEX_ASCII[8*(15 - nib) +: 8]);
        end
    endfunction

    function automatic bit cont_byte(logic [7:0] b);
        return b >= 8'h80 && b <= 8'hbf;
    endfunction

    // Judge the buffered bytes one character or sequence at a time
    function automatic void drain_buffer(bit at_end);
        logic [7:0]  c1, c2, c3, c4;
        logic [20:0] cp;
        logic [20:0] w;
        int unsigned need, used;
        bit          ok, waiting;
        waiting = 1'b0;
        while (utf_n > 0 && !str_halted && !waiting) begin
            c1 = utf_buf[0];
            c2 = utf_buf[1];
            c3 = utf_buf[2];
            c4 = utf_buf[3];
            used = 1;
            ok = 1'b0;
            if (c1 < 8'h80) begin
                if (c1 >= 8'h20 && c1 != jse_pkg::CH_QUOT && c1 != jse_pkg::CH_BSL) begin
                    write_char(c1);
                end else begin
                    case (c1)
                        jse_pkg::CH_BSL: begin
                            write_char(jse_pkg::CH_BSL);
                            write_char(jse_pkg::CH_BSL);
                        end
                        jse_pkg::CH_QUOT: begin
                            write_char(jse_pkg::CH_BSL);
                            write_char(jse_pkg::CH_QUOT);
                        end
                        jse_pkg::CTL_BS: begin
                            write_char(jse_pkg::CH_BSL);
                            write_char(jse_pkg::CH_B);
                        end
                        jse_pkg::CTL_FF: begin
                            write_char(jse_pkg::CH_BSL);
                            write_char(jse_pkg::CH_F);
                        end
                        jse_pkg::CTL_LF: begin
                            write_char(jse_pkg::CH_BSL);
                            write_char(jse_pkg::CH_N);
                        end
                        jse_pkg::CTL_CR: begin
                            write_char(jse_pkg::CH_BSL);
                            write_char(jse_pkg::CH_R);
                        end
                        jse_pkg::CTL_TAB: begin
                            write_char(jse_pkg::CH_BSL);
                            write_char(jse_pkg::CH_T);
                        end
                        default: write_u4({8'h00, c1});
                    endcase
                end
            end else begin
                if (c1 >= 8'hc0 && c1 <= 8'hdf) need = 1;
                else if (c1 >= 8'he0 && c1 <= 8'hef) need = 2;
                else if (c1 >= 8'hf0 && c1 <= 8'hf7) need = 3;
                else need = 0;

                if (need > 0 && utf_n - 1 < need && !at_end) begin
                    waiting = 1'b1;
                end else begin
                    if (need == 1 && utf_n >= 2) begin
                        if (c1 >= 8'hc2 && cont_byte(c2)) begin
                            cp = {10'd0, c1[4:0], c2[5:0]};
                            write_u4(cp[15:0]);
                            ok = 1'b1;
                            used = 2;
                        end
                    end else if (need == 2 && utf_n >= 3) begin
                        if ((c1 != 8'he0 || c2 >= 8'ha0) && (c1 != 8'hed || c2 <= 8'h9f) &&
                            cont_byte(c2) && cont_byte(c3)) begin
                            cp = {5'd0, c1[3:0], c2[5:0], c3[5:0]};
                            write_u4(cp[15:0]);
                            ok = 1'b1;
                            used = 3;
                        end
                    end else if (need == 3 && utf_n >= 4) begin
                        if ((c1 != 8'hf0 || c2 >= 8'h90) && c1 <= 8'hf4 &&
                            cont_byte(c2) && cont_byte(c3) && cont_byte(c4)) begin
                            cp = {c1[2:0], c2[5:0], c3[5:0], c4[5:0]};
                            if (cp <= jse_pkg::CP_MAX) begin
                                if (cp <= jse_pkg::CP_BMPMAX) begin
                                    write_u4(cp[15:0]);
                                end else begin
                                    w = cp - jse_pkg::CP_SUPP;
                                    write_u4(jse_pkg::SUR_HI | {6'd0, w[19:10]});
                                    write_u4(jse_pkg::SUR_LO | {6'd0, w[9:0]});
                                end
                                ok = 1'b1;
                                used = 4;
                            end
                        end
                    end
                    // Bad sequence: replacement char, only the lead byte is consumed
                    if (!ok) begin
                        write_u4(jse_pkg::CP_REPL);
                        used = 1;
                    end
                end
            end
            if (!waiting) begin
                for (int k = 0; k + used < utf_n && k + used < 4; k++)
                    utf_buf[k] = utf_buf[k + used];
                utf_n = utf_n - used;
            end
        end
    endfunction

    // Expected output chars for one accepted input byte
    function automatic void predict_byte(logic [7:0] b);
        str_halted = 1'b0;
        utf_n = held_n;
        for (int k = 0; k < 4; k++)
            utf_buf[k] = (k < held_n) ? held_q[k] : 8'h00;
        if (b != jse_pkg::CH_NUL) begin
            if (!str_aborted) begin
                utf_buf[utf_n] = b;
                utf_n = utf_n + 1;
                drain_buffer(1'b0);
                if (!str_halted) begin
                    for (int k = 0; k < 3; k++)
                        held_q[k] = (k < utf_n) ? utf_buf[k] : 8'h00;
                    held_n = utf_n;
                end
            end
        end else begin
            if (!str_aborted) begin
                drain_buffer(1'b1);
                if (!str_halted) begin
                    if (chars_written < out_cap) begin
                        chars_written = chars_written + 16'd1;
                        push_char(jse_pkg::CH_NUL, 1'b1, 1'b0, chars_written);
                    end else begin
                        raise_overflow();
                    end
                end
            end
            // Terminator always returns the string state to reset
            for (int k = 0; k < 3; k++)
                held_q[k] = 8'h00;
            held_n = 0;
            chars_written = 16'h0000;
            str_aborted = 1'b0;
        end
    endfunction

    function automatic void queue_byte(logic [7:0] b);
        pending_bytes.push_back(b);
        bytes_total++;
    endfunction

    function automatic logic [7:0] rand_cont();
        return 8'($urandom_range(8'h80, 8'hbf));
    endfunction

    // One random character, mostly well formed, sometimes broken
    function automatic void queue_random_char();
        int unsigned pick, need, conts;
        logic [7:0]  lead;
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            queue_byte(8'($urandom_range(8'h20, 8'h7f)));
        end else if (pick < 50) begin
            case ($urandom_range(0, 7))
                0: queue_byte(jse_pkg::CH_QUOT);
                1: queue_byte(jse_pkg::CH_BSL);
                2: queue_byte(jse_pkg::CTL_BS);
                3: queue_byte(jse_pkg::CTL_FF);
                4: queue_byte(jse_pkg::CTL_LF);
                5: queue_byte(jse_pkg::CTL_CR);
                6: queue_byte(jse_pkg::CTL_TAB);
                default: queue_byte(8'($urandom_range(1, jse_pkg::CTL_LAST)));
            endcase
        end else if (pick < 60) begin
            queue_byte(8'($urandom_range(8'hc2, 8'hdf)));
            queue_byte(rand_cont());
        end else if (pick < 70) begin
            lead = 8'($urandom_range(8'he0, 8'hef));
            queue_byte(lead);
            if (lead == 8'he0) queue_byte(8'($urandom_range(8'ha0, 8'hbf)));
            else if (lead == 8'hed) queue_byte(8'($urandom_range(8'h80, 8'h9f)));
            else queue_byte(rand_cont());
            queue_byte(rand_cont());
        end else if (pick < 80) begin
            lead = 8'($urandom_range(8'hf0, 8'hf4));
            queue_byte(lead);
            if (lead == 8'hf0) queue_byte(8'($urandom_range(8'h90, 8'hbf)));
            else if (lead == 8'hf4) queue_byte(8'($urandom_range(8'h80, 8'h8f)));
            else queue_byte(rand_cont());
            queue_byte(rand_cont());
            queue_byte(rand_cont());
        end else if (pick < 87) begin
            // Just past the valid ranges: overlong, surrogate, above the max
            case ($urandom_range(0, 5))
                0: begin
                    queue_byte(8'($urandom_range(8'hc0, 8'hc1)));
                    queue_byte(rand_cont());
                end
                1: begin
                    queue_byte(8'he0);
                    queue_byte(8'($urandom_range(8'h80, 8'h9f)));
                    queue_byte(rand_cont());
                end
                2: begin
                    queue_byte(8'hed);
                    queue_byte(8'($urandom_range(8'ha0, 8'hbf)));
                    queue_byte(rand_cont());
                end
                3: begin
                    queue_byte(8'hf0);
                    queue_byte(8'($urandom_range(8'h80, 8'h8f)));
                    queue_byte(rand_cont());
                    queue_byte(rand_cont());
                end
                4: begin
                    queue_byte(8'hf4);
                    queue_byte(8'($urandom_range(8'h90, 8'hbf)));
                    queue_byte(rand_cont());
                    queue_byte(rand_cont());
                end
                default: begin
                    queue_byte(8'($urandom_range(8'hf5, 8'hf7)));
                    queue_byte(rand_cont());
                    queue_byte(rand_cont());
                    queue_byte(rand_cont());
                end
            endcase
        end else if (pick < 94) begin
            // Truncated sequence: lead with too few continuation bytes
            need = $urandom_range(1, 3);
            if (need == 1) lead = 8'($urandom_range(8'hc2, 8'hdf));
            else if (need == 2) lead = 8'($urandom_range(8'he1, 8'hec));
            else lead = 8'($urandom_range(8'hf1, 8'hf3));
            queue_byte(lead);
            conts = $urandom_range(0, need - 1);
            repeat (conts) queue_byte(rand_cont());
        end else begin
            queue_byte(8'($urandom_range(1, 255)));
        end
    endfunction

    task automatic queue_strings(int n_bytes);
        int start;
        start = bytes_total;
        while (bytes_total - start < n_bytes) begin
            repeat ($urandom_range(0, 10)) queue_random_char();
            queue_byte(jse_pkg::CH_NUL);
        end
    endtask

    // Wait until everything sent has been answered and the pipeline is quiet
    task automatic wait_drained();
        while (bytes_taken != bytes_total || expected_chars.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_capacity(logic [15:0] cap);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= cap;
        out_cap = cap;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Stimulus sequence
    initial begin
        directed_bytes = '{
            8'h22, 8'h5c, 8'h08, 8'h0c, 8'h0a, 8'h0d, 8'h09, 8'h01, 8'h1f, 8'h20, 8'h7f,
            8'h00,
            8'hf4, 8'h8f, 8'hbf, 8'hbf, 8'hed, 8'ha0, 8'h80, 8'hc0, 8'h80, 8'hff,
            8'he2, 8'h82, 8'h00
        };
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset capacity: escapes, max code point, invalid and cut-short sequences
        foreach (directed_bytes[i]) queue_byte(directed_bytes[i]);
        wait_drained();

        write_capacity(16'd1);
        queue_strings(10);
        wait_drained();

        write_capacity(16'd7);
        queue_strings(20);
        wait_drained();

        write_capacity(16'd20);
        queue_strings(20);
        wait_drained();

        // Last part: full capacity, both sides run without idling
        write_capacity(16'hffff);
        idle_on = 1'b0;
        queue_strings(20);
        wait_drained();

        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Driver: new input bytes and ready pattern at the falling edge
    always @(negedge aclk) begin
        if (!s_valid || bytes_taken == bytes_sent) begin
            if (in_gap > 0) begin
                in_gap--;
                s_valid <= 1'b0;
            end else if (aresetn && pending_bytes.size() > 0) begin
                if (idle_on && $urandom_range(0, 5) == 0) begin
                    in_gap = $urandom_range(0, 15);
                    s_valid <= 1'b0;
                end else begin
                    s_valid <= 1'b1;
                    s_in_byte <= pending_bytes.pop_front();
                    bytes_sent++;
                end
            end else begin
                s_valid <= 1'b0;
            end
        end

        if (out_gap > 0) begin
            out_gap--;
            m_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            out_gap = $urandom_range(0, 15);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Monitor: predict on each input transaction, check each output transaction
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                predict_byte(s_in_byte);
                bytes_taken++;
            end
            if (m_valid && m_ready) begin
                if (expected_chars.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected output: char %h done %b ovf %b len %0d",
                                 m_out_char, m_done_res, m_overflow, m_total_length);
                end else begin
                    want = expected_chars.pop_front();
                    if (want.ch !== m_out_char || want.done !== m_done_res ||
                        want.ovf !== m_overflow || want.len !== m_total_length) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: expected char %h done %b ovf %b len %0d,",
                                      " got char %h done %b ovf %b len %0d"},
                                     want.ch, want.done, want.ovf, want.len,
                                     m_out_char, m_done_res, m_overflow, m_total_length);
                    end
                end
            end
        end
    end

    // Watchdog on cycles with no transaction at all
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

endmodule

// ===== sim.f =====
+incdir+sv
sv/jse_pkg.sv
sv/jse_front.sv
sv/jse_queue.sv
sv/jse_back.sv
sv/json_string_escaper_utf8.sv
sv/jse_checker.sv
test/testbench.sv
